// ===== sv/qat_pkg.sv =====
// Package for the quoted argument tokenizer.
// Holds the item types, the scan mode enum, byte constants and the escape table.
// No dependencies.
package qat_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       arg_end;
    logic       line_done;
    logic       unclosed_quote;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_PLAIN   = 3'd1,
    MODE_SQUOTE  = 3'd2,
    MODE_DQUOTE  = 3'd3,
    MODE_SLASH   = 3'd4
  } scan_mode_t;

  localparam logic       REG_SEPARATOR   = 1'b0;
  localparam logic       REG_REGEXP_MODE = 1'b1;

  localparam logic [7:0] SEPARATOR_RESET = 8'h20;
  localparam logic [7:0] CH_SQ           = 8'h27;
  localparam logic [7:0] CH_DQ           = 8'h22;
  localparam logic [7:0] CH_SLASH        = 8'h2F;
  localparam logic [7:0] CH_BSL          = 8'h5C;
  localparam logic [7:0] CH_SPACE        = 8'h20;

  function automatic logic [7:0] xlat_escape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h30:   r = 8'h00;
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0B;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/qat_chan_if.sv =====
// Valid/ready channel interface carrying one payload per transfer.
// The payload type is a parameter; used with the item types of qat_pkg.
interface qat_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/qat_scanner.sv =====
// Scan state and per-byte decision logic of the tokenizer.
// Depends on qat_pkg for item types, scan modes and the escape table.
module qat_scanner (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  qat_pkg::in_item_t item,
  input  logic [7:0]        separator,
  input  logic              regexp_mode,
  output logic              res_valid,
  output qat_pkg::out_item_t res
);
  import qat_pkg::*;

  scan_mode_t mode, mode_next;
  logic       escape_pending, escape_pending_next;
  logic       arg_truncated, arg_truncated_next;
  logic       hold_valid, hold_valid_next;
  logic [7:0] hold_byte, hold_byte_next;

  always_comb begin
    logic [7:0] c;
    logic       quoting;
    logic       put_req;
    logic [7:0] put_val;
    logic       r_valid;
    logic       ae;
    logic       ld;
    logic       uq;

    c        = item.char_byte;
    quoting  = (separator == CH_SPACE);
    put_req  = 1'b0;
    put_val  = c;
    r_valid  = 1'b0;
    ae       = 1'b0;
    ld       = 1'b0;
    uq       = 1'b0;

    mode_next           = mode;
    escape_pending_next = escape_pending;
    arg_truncated_next  = arg_truncated;
    hold_valid_next     = hold_valid;
    hold_byte_next      = hold_byte;

    if (item.end_of_line) begin
      ld = 1'b1;
      if (mode == MODE_PLAIN) begin
        ae = 1'b1;
      end else if (mode == MODE_SQUOTE || mode == MODE_DQUOTE || mode == MODE_SLASH) begin
        uq = 1'b1;
      end
    end else begin
      unique case (mode)
        MODE_PLAIN: begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            put_req = 1'b1;
          end else if (c == separator) begin
            ae = 1'b1;
          end else if (c == CH_BSL) begin
            escape_pending_next = 1'b1;
          end else begin
            put_req = 1'b1;
          end
        end
        MODE_SQUOTE: begin
          if (c == CH_SQ) begin
            ae = 1'b1;
          end else begin
            put_req = 1'b1;
          end
        end
        MODE_DQUOTE: begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            put_req = 1'b1;
            put_val = xlat_escape(c);
          end else if (c == CH_DQ) begin
            ae = 1'b1;
          end else if (c == CH_BSL) begin
            escape_pending_next = 1'b1;
          end else begin
            put_req = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (escape_pending) begin
            put_req = 1'b1;
            if (c == CH_SLASH) begin
              escape_pending_next = 1'b0;
            end else if (c == CH_BSL) begin
              put_val = CH_BSL;
            end else begin
              escape_pending_next = 1'b0;
              put_val = CH_BSL;
              hold_byte_next = c;
              hold_valid_next = 1'b1;
            end
          end else if (hold_valid) begin
            put_req = 1'b1;
            put_val = hold_byte;
            hold_valid_next = 1'b0;
            if (c == CH_SLASH) begin
              ae = 1'b1;
            end else if (c == CH_BSL) begin
              escape_pending_next = 1'b1;
            end else begin
              hold_byte_next = c;
              hold_valid_next = 1'b1;
            end
          end else if (c == CH_SLASH) begin
            ae = 1'b1;
          end else if (c == CH_BSL) begin
            escape_pending_next = 1'b1;
          end else begin
            put_req = 1'b1;
          end
        end
        default: begin
          if (quoting && c == CH_SQ) begin
            mode_next = MODE_SQUOTE;
          end else if (quoting && c == CH_DQ) begin
            mode_next = MODE_DQUOTE;
          end else if (quoting && c == CH_SLASH && regexp_mode) begin
            mode_next = MODE_SLASH;
          end else if (c != separator) begin
            mode_next = MODE_PLAIN;
            if (c == CH_BSL) begin
              escape_pending_next = 1'b1;
            end else begin
              put_req = 1'b1;
            end
          end
        end
      endcase
    end

    // A zero byte truncates the argument; nothing more is shown until it ends.
    if (put_req && !arg_truncated) begin
      if (put_val == 8'h00) begin
        arg_truncated_next = 1'b1;
      end else begin
        r_valid = 1'b1;
      end
    end

    if (ae || ld) begin
      mode_next           = MODE_BETWEEN;
      escape_pending_next = 1'b0;
      arg_truncated_next  = 1'b0;
      hold_valid_next     = 1'b0;
    end

    res_valid          = r_valid || ae || ld;
    res.byte_valid     = r_valid;
    res.out_byte       = r_valid ? put_val : 8'h00;
    res.arg_end        = ae;
    res.line_done      = ld;
    res.unclosed_quote = uq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_BETWEEN;
      escape_pending <= 1'b0;
      arg_truncated  <= 1'b0;
      hold_valid     <= 1'b0;
    end else if (step) begin
      mode           <= mode_next;
      escape_pending <= escape_pending_next;
      arg_truncated  <= arg_truncated_next;
      hold_valid     <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hold_byte <= hold_byte_next;
    end
  end

endmodule

// ===== sv/qat_out_reg.sv =====
// Result register that drives the output channel.
// Depends on qat_pkg for the result type and on qat_chan_if.
module qat_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  qat_pkg::out_item_t load_item,
  output logic               can_load,
  qat_chan_if.source         results
);
  import qat_pkg::*;

  logic      valid;
  out_item_t item;

  assign can_load        = !valid || results.ready;
  assign results.valid   = valid;
  assign results.payload = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      item <= load_item;
    end
  end

endmodule

// ===== sv/quoted_argument_tokenizer_top.sv =====
// Quoted argument tokenizer, top level: input register, configuration registers,
// scanner and result register. Depends on qat_pkg, qat_chan_if, qat_scanner, qat_out_reg.
// A result passes the input register, then the result register, and is offered in the
// cycle after the edge that loads the result register. Throughput is one item per cycle
// while the result register can load. Items that cause no result make no output transfer.
// Synchronous reset clears scan mode and flags, sets separator to 32, regexp mode to 0.
module quoted_argument_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  qat_chan_if.sink   items,
  qat_chan_if.source results,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import qat_pkg::*;

  logic [7:0] separator_value;
  logic       regexp_mode;
  logic       stage_valid;
  in_item_t   stage_item;
  logic       can_load;
  logic       step;
  logic       res_valid;
  out_item_t  res;

  assign step        = stage_valid && can_load;
  assign items.ready = !stage_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_value <= SEPARATOR_RESET;
      regexp_mode     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEPARATOR:   separator_value <= cfg_data;
        REG_REGEXP_MODE: regexp_mode <= cfg_data[0];
        default:         regexp_mode <= regexp_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (items.ready) begin
      stage_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      stage_item <= items.payload;
    end
  end

  qat_scanner u_scanner (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (stage_item),
    .separator   (separator_value),
    .regexp_mode (regexp_mode),
    .res_valid   (res_valid),
    .res         (res)
  );

  qat_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_item (res),
    .can_load  (can_load),
    .results   (results)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for quoted_argument_tokenizer_top.
// Drives random and directed argument lines and checks each result against a predictor.
// Depends on qat_pkg, qat_chan_if and the tokenizer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qat_pkg::*;

  localparam int STALL_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int HOLD_OFF_CYCLES = 80;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  qat_chan_if #(.payload_t(in_item_t))  items_ch ();
  qat_chan_if #(.payload_t(out_item_t)) results_ch ();

  quoted_argument_tokenizer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  logic [7:0] cur_sep;
  logic       cur_regexp;
  scan_mode_t tok_mode;
  logic       tok_esc;
  logic       tok_trunc;
  logic       tok_hold_v;
  logic [7:0] tok_hold;
  logic       emit_v;
  logic [7:0] emit_b;

  int  errors;
  int  items_queued;
  int  items_sent;
  int  results_checked;
  int  lines_checked;
  int  unclosed_lines;
  int  settings_used;
  int  idle_pct;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  bit  hold_request;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] dq_escape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    case (c)
      "0": r = 8'h00;
      "a": r = 8'h07;
      "b": r = 8'h08;
      "f": r = 8'h0C;
      "n": r = 8'h0A;
      "r": r = 8'h0D;
      "t": r = 8'h09;
      "v": r = 8'h0B;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic void emit(input logic [7:0] b);
    if (!tok_trunc) begin
      if (b == 8'h00) begin
        tok_trunc = 1'b1;
      end else begin
        emit_v = 1'b1;
        emit_b = b;
      end
    end
  endfunction

  function automatic void reset_scan();
    tok_mode   = MODE_BETWEEN;
    tok_esc    = 1'b0;
    tok_trunc  = 1'b0;
    tok_hold_v = 1'b0;
    tok_hold   = 8'h00;
  endfunction

  function automatic void scan_item(input in_item_t it);
    out_item_t  r;
    logic       ends;
    logic       quoting;
    logic [7:0] c;
    c       = it.char_byte;
    ends    = 1'b0;
    quoting = (cur_sep == CH_SPACE);
    r       = '0;
    emit_v  = 1'b0;
    emit_b  = 8'h00;
    if (it.end_of_line) begin
      r.line_done = 1'b1;
      if (tok_mode == MODE_PLAIN) ends = 1'b1;
      else if (tok_mode != MODE_BETWEEN) r.unclosed_quote = 1'b1;
      reset_scan();
    end else begin
      case (tok_mode)
        MODE_PLAIN: begin
          if (tok_esc) begin
            tok_esc = 1'b0;
            emit(c);
          end else if (c == cur_sep) begin
            ends = 1'b1;
          end else if (c == CH_BSL) begin
            tok_esc = 1'b1;
          end else begin
            emit(c);
          end
        end
        MODE_SQUOTE: begin
          if (c == CH_SQ) ends = 1'b1;
          else emit(c);
        end
        MODE_DQUOTE: begin
          if (tok_esc) begin
            tok_esc = 1'b0;
            emit(dq_escape(c));
          end else if (c == CH_DQ) begin
            ends = 1'b1;
          end else if (c == CH_BSL) begin
            tok_esc = 1'b1;
          end else begin
            emit(c);
          end
        end
        MODE_SLASH: begin
          if (tok_esc) begin
            if (c == CH_SLASH) begin
              tok_esc = 1'b0;
              emit(c);
            end else if (c == CH_BSL) begin
              emit(CH_BSL);
            end else begin
              tok_esc = 1'b0;
              emit(CH_BSL);
              tok_hold   = c;
              tok_hold_v = 1'b1;
            end
          end else if (tok_hold_v) begin
            emit(tok_hold);
            tok_hold_v = 1'b0;
            tok_hold   = 8'h00;
            if (c == CH_SLASH) begin
              ends = 1'b1;
            end else if (c == CH_BSL) begin
              tok_esc = 1'b1;
            end else begin
              tok_hold   = c;
              tok_hold_v = 1'b1;
            end
          end else if (c == CH_SLASH) begin
            ends = 1'b1;
          end else if (c == CH_BSL) begin
            tok_esc = 1'b1;
          end else begin
            emit(c);
          end
        end
        default: begin
          if (quoting && c == CH_SQ) begin
            tok_mode = MODE_SQUOTE;
          end else if (quoting && c == CH_DQ) begin
            tok_mode = MODE_DQUOTE;
          end else if (quoting && c == CH_SLASH && cur_regexp) begin
            tok_mode = MODE_SLASH;
          end else if (c != cur_sep) begin
            tok_mode = MODE_PLAIN;
            if (c == CH_BSL) tok_esc = 1'b1;
            else emit(c);
          end
        end
      endcase
      if (ends) reset_scan();
    end
    if (emit_v || ends || r.line_done) begin
      r.byte_valid = emit_v;
      r.out_byte   = emit_v ? emit_b : 8'h00;
      r.arg_end    = ends;
      expected_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 20)
      $display("testbench: result %0d: %s is %0h, expected %0h",
               results_checked, what, got, want);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", got, 0);
    end else begin
      want = expected_results.pop_front();
      if (got.byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
      if (got.out_byte !== want.out_byte)
        report_mismatch("out_byte", got.out_byte, want.out_byte);
      if (got.arg_end !== want.arg_end)
        report_mismatch("arg_end", got.arg_end, want.arg_end);
      if (got.line_done !== want.line_done)
        report_mismatch("line_done", got.line_done, want.line_done);
      if (got.unclosed_quote !== want.unclosed_quote)
        report_mismatch("unclosed_quote", got.unclosed_quote, want.unclosed_quote);
      if (want.line_done) lines_checked++;
      if (want.unclosed_quote) unclosed_lines++;
    end
    results_checked++;
  endtask

  // Driver: valid stays up until the transfer completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (items_ch.valid && items_ch.ready) begin
        scan_item(items_ch.payload);
        void'(pending_items.pop_front());
        items_sent++;
      end
      if (items_ch.valid && !items_ch.ready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        items_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && $urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(0, 3);
        items_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        items_ch.valid   <= 1'b1;
        items_ch.payload <= pending_items[0];
      end else begin
        items_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every result transfer and paces ready.
  always @(posedge clk) begin
    if (!rst) begin
      if (results_ch.valid && results_ch.ready) check_result(results_ch.payload);
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        results_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        results_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 3);
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: no transfer for %0d cycles", STALL_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(input logic [7:0] c, input logic eol);
    in_item_t it;
    it.char_byte   = c;
    it.end_of_line = eol;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_eol();
    add_item($urandom_range(0, 255), 1'b1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] plain_byte(input logic [7:0] avoid);
    logic [7:0] b;
    do begin
      case ($urandom_range(0, 31))
        0:       b = 8'h00;
        1, 2, 3: b = $urandom_range(0, 255);
        4, 5:    b = $urandom_range(8'h30, 8'h39);
        default: b = $urandom_range(8'h61, 8'h7A);
      endcase
    end while (b == avoid || b == cur_sep || b == CH_BSL);
    return b;
  endfunction

  function automatic logic [7:0] escaped_byte();
    string      letters;
    logic [7:0] b;
    letters = "0abfnrtv";
    case ($urandom_range(0, 6))
      0:       b = CH_BSL;
      1:       b = CH_SLASH;
      2:       b = CH_DQ;
      3, 4:    b = letters[$urandom_range(0, 7)];
      default: b = $urandom_range(0, 255);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = cur_sep;
      1:       b = CH_SQ;
      2:       b = CH_DQ;
      3:       b = CH_SLASH;
      4:       b = CH_BSL;
      5:       b = 8'h00;
      default: b = $urandom_range(0, 255);
    endcase
    return b;
  endfunction

  task automatic add_arg(output bit open_left);
    int         kind;
    int         n;
    logic [7:0] closer;
    kind      = $urandom_range(0, 3);
    open_left = 1'b0;
    if (kind == 3 && !cur_regexp) kind = 0;
    if (kind == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) begin
          add_item(CH_BSL, 1'b0);
          add_item(escaped_byte(), 1'b0);
        end else begin
          add_item(plain_byte(CH_BSL), 1'b0);
        end
      end
    end else begin
      closer = (kind == 1) ? CH_SQ : (kind == 2) ? CH_DQ : CH_SLASH;
      n      = $urandom_range(0, 7);
      add_item(closer, 1'b0);
      repeat (n) begin
        if (kind != 1 && $urandom_range(0, 3) == 0) begin
          add_item(CH_BSL, 1'b0);
          add_item(escaped_byte(), 1'b0);
        end else begin
          add_item(plain_byte(closer), 1'b0);
        end
      end
      if ($urandom_range(0, 11) == 0) open_left = 1'b1;
      else add_item(closer, 1'b0);
    end
  endtask

  task automatic add_line();
    int nargs;
    bit open_left;
    open_left = 1'b0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 24)) add_item(noise_byte(), 1'b0);
    end else begin
      nargs = $urandom_range(0, 5);
      repeat ($urandom_range(0, 2)) add_item(cur_sep, 1'b0);
      for (int a = 0; a < nargs && !open_left; a++) begin
        add_arg(open_left);
        if (!open_left) begin
          if (a == nargs - 1 && $urandom_range(0, 3) == 0)
            add_item(CH_BSL, 1'b0);
          else
            repeat ($urandom_range((a == nargs - 1) ? 0 : 1, 3)) add_item(cur_sep, 1'b0);
        end
      end
    end
    add_eol();
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEPARATOR) cur_sep = val;
    else cur_regexp = val[0];
  endtask

  task automatic run_phase(input logic [7:0] sep, input logic rx, input int n_items,
                           input int pct, input bit squeeze);
    int start;
    settle();
    write_reg(REG_SEPARATOR, sep);
    write_reg(REG_REGEXP_MODE, rx);
    settings_used++;
    @(negedge clk);
    idle_pct = pct;
    start    = items_queued;
    while (items_queued - start < n_items) add_line();
    if (squeeze) hold_request = 1'b1;
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_SEPARATOR;
    cfg_data         = 8'h00;
    items_ch.valid   = 1'b0;
    items_ch.payload = '0;
    results_ch.ready = 1'b0;
    cur_sep          = SEPARATOR_RESET;
    cur_regexp       = 1'b0;
    errors           = 0;
    items_queued     = 0;
    items_sent       = 0;
    results_checked  = 0;
    lines_checked    = 0;
    unclosed_lines   = 0;
    settings_used    = 0;
    idle_pct         = 0;
    send_gap         = 0;
    stall_left       = 0;
    hold_left        = 0;
    hold_request     = 1'b0;
    quiet_cycles     = 0;
    reset_scan();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: escapes in plain, double-quoted and slash arguments, zero bytes, a
    // backslash before the terminator, an empty line and an unclosed double quote.
    write_reg(REG_REGEXP_MODE, 1'b1);
    @(negedge clk);
    idle_pct = 20;
    add_text("\\a 'b\"' \"\\t\\0z\" /\\x\\//");
    add_eol();
    add_eol();
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b0);
    add_text(" \\");
    add_eol();
    add_text("\"");
    add_eol();

    run_phase(CH_SPACE, 1'b1, 300, 25, 1'b1);
    run_phase(CH_SPACE, 1'b0, 250, 15, 1'b0);
    run_phase(8'h2C,    1'b1, 200, 10, 1'b0);
    run_phase(8'h00,    1'b0, 200, 0,  1'b0);
    run_phase(8'hFF,    1'b1, 200, 30, 1'b1);
    run_phase(CH_BSL,   1'b0, 150, 15, 1'b0);
    run_phase(CH_SQ,    1'b1, 150, 20, 1'b0);
    run_phase(CH_SPACE, 1'b1, 300, 0,  1'b0);
    settle();

    $display("testbench: %0d items sent, %0d results checked, %0d lines (%0d unclosed)",
             items_sent, results_checked, lines_checked, unclosed_lines);
    $display("testbench: %0d separator and regexp settings, %0d mismatches",
             settings_used, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/qat_pkg.sv
sv/qat_chan_if.sv
sv/qat_scanner.sv
sv/qat_out_reg.sv
sv/quoted_argument_tokenizer_top.sv
sim/testbench.sv
